/* hdl/cmse_pkg.sv */
// Shared types, character codes and helpers for the cursor-motion string expander.
// No dependencies.
package cmse_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DEC   = 8'h64;
    localparam logic [7:0] CH_W2    = 8'h32;
    localparam logic [7:0] CH_W3    = 8'h33;
    localparam logic [7:0] CH_BYTE  = 8'h2E;
    localparam logic [7:0] CH_REV   = 8'h72;
    localparam logic [7:0] CH_INC   = 8'h69;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [9:0] VALUE_MAX = 10'd999;

    localparam logic [1:0] WIDTH_1 = 2'd1;
    localparam logic [1:0] WIDTH_2 = 2'd2;
    localparam logic [1:0] WIDTH_3 = 2'd3;

    localparam int CMSE_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       is_dec;
        logic [1:0] width;
        logic [9:0] value;
        logic [7:0] lit;
    } t_cmd;

    function automatic logic [9:0] clamp_value(input logic [9:0] v);
        return (v > VALUE_MAX) ? VALUE_MAX : v;
    endfunction

    function automatic logic [9:0] sat_inc(input logic [9:0] v);
        return (v < VALUE_MAX) ? v + 10'd1 : v;
    endfunction

endpackage

/* hdl/cmse_if.sv */
// Valid/ready channel interfaces for template characters and output bytes.
// Depends on nothing.
interface cmse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] template_char;
    logic       first_of_template;
    logic [9:0] target_column;
    logic [9:0] target_row;

    modport source (output valid, template_char, first_of_template, target_column,
                    target_row, input ready);
    modport sink (input valid, template_char, first_of_template, target_column,
                  target_row, output ready);
endinterface

interface cmse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, out_char, last_of_run, input ready);
    modport sink (input valid, out_char, last_of_run, output ready);
endinterface

/* hdl/cmse_front.sv */
// Front end: accepts template characters, tracks escape and row/column state,
// and issues emit commands. Depends on cmse_pkg and cmse_in_if.
module cmse_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cmse_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output cmse_pkg::t_cmd  o_cmd
);
    import cmse_pkg::*;

    logic       r_esc, n_esc;
    logic [9:0] r_cur, n_cur;
    logic [9:0] r_oth, n_oth;
    logic [9:0] cur_eff, oth_eff;
    logic       esc_eff;
    logic       accept;
    logic       emit;
    t_cmd       cmd;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        cur_eff = i_in.first_of_template ? clamp_value(i_in.target_row)    : r_cur;
        oth_eff = i_in.first_of_template ? clamp_value(i_in.target_column) : r_oth;
        esc_eff = i_in.first_of_template ? 1'b0 : r_esc;

        n_esc      = esc_eff;
        n_cur      = cur_eff;
        n_oth      = oth_eff;
        emit       = 1'b0;
        cmd.is_dec = 1'b0;
        cmd.width  = WIDTH_1;
        cmd.value  = cur_eff;
        cmd.lit    = i_in.template_char;

        if (esc_eff) begin
            n_esc = 1'b0;
            unique case (i_in.template_char) inside
                CH_DEC, CH_W2, CH_W3: begin
                    emit       = 1'b1;
                    cmd.is_dec = 1'b1;
                    cmd.width  = (i_in.template_char == CH_W3) ? WIDTH_3 :
                                 (i_in.template_char == CH_W2) ? WIDTH_2 : WIDTH_1;
                    n_cur      = oth_eff;
                    n_oth      = cur_eff;
                end
                CH_BYTE: begin
                    emit    = 1'b1;
                    cmd.lit = cur_eff[7:0];
                    n_cur   = oth_eff;
                    n_oth   = cur_eff;
                end
                CH_REV: begin
                    n_cur = oth_eff;
                    n_oth = cur_eff;
                end
                CH_INC: begin
                    n_cur = sat_inc(cur_eff);
                    n_oth = sat_inc(oth_eff);
                end
                CH_PCT: begin
                    emit    = 1'b1;
                    cmd.lit = CH_PCT;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end else if (i_in.template_char == CH_PCT) begin
            n_esc = 1'b1;
        end else begin
            emit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_cur <= '0;
            r_oth <= '0;
        end else if (accept) begin
            r_esc <= n_esc;
            r_cur <= n_cur;
            r_oth <= n_oth;
        end
    end

    assign o_push = accept && emit;
    assign o_cmd  = cmd;

endmodule

/* hdl/cmse_queue.sv */
// Short command queue between front and back ends.
// Depends on cmse_pkg.
module cmse_queue #(
    parameter int DEPTH = cmse_pkg::CMSE_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmse_pkg::t_cmd  i_data,
    output logic            o_full,
    output logic            o_valid,
    output cmse_pkg::t_cmd  o_head,
    input  logic            i_pop
);
    import cmse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* hdl/cmse_back.sv */
// Back end: turns emit commands into decimal or literal bytes and sends one
// byte per cycle while o_out.ready is high. Depends on cmse_pkg and cmse_out_if.
module cmse_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cmse_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    cmse_out_if.source      o_out
);
    import cmse_pkg::*;

    logic       r_valid;
    logic [7:0] r_bytes [3];
    logic [1:0] r_idx;
    logic [1:0] r_last_idx;

    logic [3:0] hund, tens, ones;
    logic [6:0] rem;
    logic [1:0] nd, len;
    logic [7:0] pos2, pos1, pos0;
    logic [7:0] d_bytes [3];
    logic [1:0] d_last;
    logic       at_last, load;

    always_comb begin
        hund = '0;
        for (int k = 1; k < 10; k++) begin
            if (i_cmd.value >= 10'(k * 100)) hund = 4'(k);
        end
        rem  = 7'(i_cmd.value - 10'(hund) * 10'd100);
        tens = '0;
        for (int k = 1; k < 10; k++) begin
            if (rem >= 7'(k * 10)) tens = 4'(k);
        end
        ones = 4'(rem - 7'(tens) * 7'd10);

        nd   = (i_cmd.value >= 10'd100) ? 2'd3 : (i_cmd.value >= 10'd10) ? 2'd2 : 2'd1;
        len  = (i_cmd.width > nd) ? i_cmd.width : nd;
        pos2 = (nd == 2'd3) ? CH_ZERO + 8'(hund) : CH_SPACE;
        pos1 = (nd != 2'd1) ? CH_ZERO + 8'(tens) : CH_SPACE;
        pos0 = CH_ZERO + 8'(ones);

        d_bytes[0] = i_cmd.lit;
        d_bytes[1] = pos0;
        d_bytes[2] = pos0;
        d_last     = 2'd0;
        if (i_cmd.is_dec) begin
            d_last = len - 2'd1;
            case (len)
                2'd3: begin
                    d_bytes[0] = pos2;
                    d_bytes[1] = pos1;
                    d_bytes[2] = pos0;
                end
                2'd2: begin
                    d_bytes[0] = pos1;
                    d_bytes[1] = pos0;
                end
                default: begin
                    d_bytes[0] = pos0;
                end
            endcase
        end
    end

    assign at_last = (r_idx == r_last_idx);
    assign load    = i_valid && (!r_valid || (o_out.ready && at_last));
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && o_out.ready) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes    <= d_bytes;
            r_last_idx <= d_last;
        end
    end

    always_comb begin
        case (r_idx)
            2'd1:    o_out.out_char = r_bytes[1];
            2'd2:    o_out.out_char = r_bytes[2];
            default: o_out.out_char = r_bytes[0];
        endcase
    end

    assign o_out.valid       = r_valid;
    assign o_out.last_of_run = at_last;

endmodule

/* hdl/cursor_motion_string_expander.sv */
// Top level of the cursor-motion string expander: front end, command queue, back end.
// Depends on cmse_pkg, cmse_if, cmse_front, cmse_queue and cmse_back.
//
//  port    direction  payload                                               item
//  i_in    sink       template_char, first_of_template, target_column/row   template char
//  o_out   source     out_char, last_of_run                                 output byte
//
// One template character is taken per cycle while the command queue has room.
// Each character yields zero to three bytes; the back end sends one byte per cycle
// while o_out.ready is high.
// From input to first byte, a command is registered in the queue, then in the output register.
// Reset is synchronous and clears escape state, coordinates, queue and output.
// An output stall fills the queue of QUEUE_DEPTH commands, then i_in.ready drops.
module cursor_motion_string_expander #(
    parameter int QUEUE_DEPTH = cmse_pkg::CMSE_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cmse_in_if.sink     i_in,
    cmse_out_if.source  o_out
);
    import cmse_pkg::*;

    logic push, full, q_valid, q_pop;
    t_cmd push_cmd, q_head;

    cmse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    cmse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    cmse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && !q_pop |=> q_valid && $stable(q_head))
        else $error("queue head changed while back end stalled");

    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_of_run |=> o_out.valid)
        else $error("byte run broken before its last byte");

endmodule
